// ===== design/bpc_pkg.sv =====
// Shared types and codes for the button press classifier.
package bpc_pkg;

   localparam int REG_WIDTH = 16;
   localparam logic [REG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [REG_WIDTH-1:0] REPEAT_PERIOD_RESET = 16'd200;

   localparam logic OP_LEVEL = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic LEVEL_PRESSED = 1'b0;

   localparam logic CSR_LONG_PRESS = 1'b0;
   localparam logic CSR_REPEAT_PERIOD = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_PRESSED = 2'd1,
      PH_LONG = 2'd2,
      PH_REPEAT = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_SHORT = 2'd0,
      EV_LONG = 2'd1,
      EV_REPEAT = 2'd2
   } event_kind_type;

endpackage

// ===== design/button_press_classifier.sv =====
// Top level of the button press classifier: registers, state core and result drain.
// Results: the first result of a request is registered and valid in the cycle after acceptance.
// Throughput: one request per cycle while each causes at most one result and rsp_ready is
// high; a tick that reports k events holds the result register until all k results are taken.
// Reset: all buttons idle, countdowns zero, long press 1000 and repeat 200 ticks,
// no results pending.
module button_press_classifier #(
   parameter int NUM_BUTTONS = 3,
   parameter int TIMER_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_op,
   input  logic [1:0] req_button,
   input  logic req_level,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_button_id,
   output logic [1:0] rsp_event_kind,
   output logic rsp_last,
   input  logic csr_write_en,
   input  logic csr_index,
   input  logic [bpc_pkg::REG_WIDTH-1:0] csr_wdata
);

   logic [bpc_pkg::REG_WIDTH-1:0] long_ticks_ff;
   logic [bpc_pkg::REG_WIDTH-1:0] repeat_ticks_ff;
   logic accept;
   logic can_load;
   logic [NUM_BUTTONS-1:0] ev_mask;
   logic [1:0] ev_kind [NUM_BUTTONS];

   assign req_ready = can_load;
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff <= bpc_pkg::LONG_PRESS_RESET;
         repeat_ticks_ff <= bpc_pkg::REPEAT_PERIOD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bpc_pkg::CSR_LONG_PRESS: long_ticks_ff <= csr_wdata;
            bpc_pkg::CSR_REPEAT_PERIOD: repeat_ticks_ff <= csr_wdata;
            default: long_ticks_ff <= long_ticks_ff;
         endcase
      end
   end

   bpc_core #(
      .NUM_BUTTONS(NUM_BUTTONS),
      .TIMER_BITS(TIMER_BITS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req_op(req_op),
      .req_button(req_button),
      .req_level(req_level),
      .long_ticks(long_ticks_ff),
      .repeat_ticks(repeat_ticks_ff),
      .ev_mask(ev_mask),
      .ev_kind(ev_kind)
   );

   bpc_evq #(
      .NUM_BUTTONS(NUM_BUTTONS)
   ) u_evq (
      .clock(clock),
      .reset(reset),
      .load(accept),
      .ev_mask(ev_mask),
      .ev_kind(ev_kind),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_button_id(rsp_button_id),
      .rsp_event_kind(rsp_event_kind),
      .rsp_last(rsp_last),
      .can_load(can_load)
   );

   a_accept_drains: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_valid) |-> (rsp_ready && rsp_last))
      else $error("request accepted while results still pending");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_unknown_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == bpc_pkg::OP_LEVEL
       && 32'(req_button) >= NUM_BUTTONS) |=> !rsp_valid)
      else $error("unknown button produced a result");

endmodule

// ===== design/bpc_core.sv =====
// Per-button press state, countdowns and event generation for one request.
module bpc_core #(
   parameter int NUM_BUTTONS = 3,
   parameter int TIMER_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic req_op,
   input  logic [1:0] req_button,
   input  logic req_level,
   input  logic [bpc_pkg::REG_WIDTH-1:0] long_ticks,
   input  logic [bpc_pkg::REG_WIDTH-1:0] repeat_ticks,
   output logic [NUM_BUTTONS-1:0] ev_mask,
   output logic [1:0] ev_kind [NUM_BUTTONS]
);

   localparam int LOAD_W = (TIMER_BITS > bpc_pkg::REG_WIDTH) ? TIMER_BITS : bpc_pkg::REG_WIDTH;

   bpc_pkg::phase_type phase_ff [NUM_BUTTONS];
   bpc_pkg::phase_type phase_in [NUM_BUTTONS];
   logic [TIMER_BITS-1:0] count_ff [NUM_BUTTONS];
   logic [TIMER_BITS-1:0] count_in [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] held_ff;
   logic [NUM_BUTTONS-1:0] held_in;
   logic [TIMER_BITS-1:0] long_load;
   logic [TIMER_BITS-1:0] repeat_load;

   function automatic logic [TIMER_BITS-1:0] load_value(input logic [bpc_pkg::REG_WIDTH-1:0] r);
      logic [LOAD_W-1:0] v;
      logic [LOAD_W-1:0] tmax;
      v = LOAD_W'(r);
      tmax = LOAD_W'((33'd1 << TIMER_BITS) - 33'd1);
      if (v == '0) begin
         v = LOAD_W'(1);
      end
      if (v > tmax) begin
         v = tmax;
      end
      return TIMER_BITS'(v);
   endfunction

   assign long_load = load_value(long_ticks);
   assign repeat_load = load_value(repeat_ticks);

   always_comb begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         phase_in[b] = phase_ff[b];
         count_in[b] = count_ff[b];
         held_in[b] = held_ff[b];
         ev_mask[b] = 1'b0;
         ev_kind[b] = bpc_pkg::EV_SHORT;
         if (accept) begin
            if (req_op == bpc_pkg::OP_LEVEL) begin
               if (32'(req_button) == b) begin
                  if (req_level == bpc_pkg::LEVEL_PRESSED) begin
                     held_in[b] = 1'b1;
                     if (phase_ff[b] == bpc_pkg::PH_IDLE) begin
                        phase_in[b] = bpc_pkg::PH_PRESSED;
                        count_in[b] = long_load;
                     end
                  end else if (held_ff[b]) begin
                     held_in[b] = 1'b0;
                     ev_mask[b] = (phase_ff[b] == bpc_pkg::PH_PRESSED);
                     phase_in[b] = bpc_pkg::PH_IDLE;
                     count_in[b] = '0;
                  end
               end
            end else if (phase_ff[b] != bpc_pkg::PH_IDLE) begin
               if (count_ff[b] > TIMER_BITS'(1)) begin
                  count_in[b] = count_ff[b] - TIMER_BITS'(1);
               end else begin
                  ev_mask[b] = 1'b1;
                  if (phase_ff[b] == bpc_pkg::PH_PRESSED) begin
                     ev_kind[b] = bpc_pkg::EV_LONG;
                     phase_in[b] = bpc_pkg::PH_LONG;
                  end else begin
                     ev_kind[b] = bpc_pkg::EV_REPEAT;
                     phase_in[b] = bpc_pkg::PH_REPEAT;
                  end
                  count_in[b] = repeat_load;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            phase_ff[b] <= bpc_pkg::PH_IDLE;
            count_ff[b] <= '0;
         end
         held_ff <= '0;
      end else begin
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            phase_ff[b] <= phase_in[b];
            count_ff[b] <= count_in[b];
         end
         held_ff <= held_in;
      end
   end

endmodule

// ===== design/bpc_evq.sv =====
// Pending event register that drains one result per cycle while rsp_ready is high, lowest button first.
module bpc_evq #(
   parameter int NUM_BUTTONS = 3
) (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  logic [NUM_BUTTONS-1:0] ev_mask,
   input  logic [1:0] ev_kind [NUM_BUTTONS],
   input  logic rsp_ready,
   output logic rsp_valid,
   output logic [1:0] rsp_button_id,
   output logic [1:0] rsp_event_kind,
   output logic rsp_last,
   output logic can_load
);

   localparam int SEL_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

   logic [NUM_BUTTONS-1:0] pend_ff;
   logic [NUM_BUTTONS-1:0] pend_in;
   logic [1:0] kind_ff [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] rest;
   logic [SEL_W-1:0] sel;

   assign rest = pend_ff & (pend_ff - NUM_BUTTONS'(1));
   assign rsp_valid = (pend_ff != '0);
   assign rsp_last = (rest == '0);
   assign can_load = !rsp_valid || (rsp_ready && rsp_last);

   always_comb begin
      sel = '0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = SEL_W'(i);
         end
      end
   end

   assign rsp_button_id = 2'(sel);
   assign rsp_event_kind = kind_ff[sel];

   always_comb begin
      pend_in = pend_ff;
      if (load) begin
         pend_in = ev_mask;
      end else if (rsp_valid && rsp_ready) begin
         pend_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            kind_ff[i] <= ev_kind[i];
         end
      end
   end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the button press classifier: directed and random requests.
`timescale 1ns / 100ps

module testbench;

   localparam int NUM_BUTTONS = 3;
   localparam int TIMER_BITS = 16;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int RANDOM_PER_PHASE = 70;
   localparam logic LEVEL_RELEASED = ~bpc_pkg::LEVEL_PRESSED;

   typedef struct {
      logic [1:0] button_id;
      bpc_pkg::event_kind_type kind;
      logic last;
   } press_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = bpc_pkg::OP_TICK;
   logic [1:0] req_button = 2'd0;
   logic req_level = LEVEL_RELEASED;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_button_id;
   logic [1:0] rsp_event_kind;
   logic rsp_last;
   logic csr_write_en = 1'b0;
   logic csr_index = bpc_pkg::CSR_LONG_PRESS;
   logic [bpc_pkg::REG_WIDTH-1:0] csr_wdata = '0;

   bpc_pkg::phase_type press_state [NUM_BUTTONS];
   logic [TIMER_BITS-1:0] count_left [NUM_BUTTONS];
   bit held_down [NUM_BUTTONS];
   logic [bpc_pkg::REG_WIDTH-1:0] long_ticks_cfg;
   logic [bpc_pkg::REG_WIDTH-1:0] repeat_ticks_cfg;

   press_event_type pending_events [$];
   int error_count = 0;
   int cycle_count = 0;
   int rsp_stall = 0;
   bit quiet_run = 1'b0;

   button_press_classifier #(
      .NUM_BUTTONS(NUM_BUTTONS),
      .TIMER_BITS(TIMER_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_button(req_button),
      .req_level(req_level),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_button_id(rsp_button_id),
      .rsp_event_kind(rsp_event_kind),
      .rsp_last(rsp_last),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || quiet_run) begin
         rsp_ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_events
      press_event_type exp_ev;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            $error("unexpected event: button_id %0d event_kind %0d last %0d",
                   rsp_button_id, rsp_event_kind, rsp_last);
            error_count++;
         end else begin
            exp_ev = pending_events.pop_front();
            if (rsp_button_id !== exp_ev.button_id) begin
               $error("button_id: expected %0d, actual %0d", exp_ev.button_id, rsp_button_id);
               error_count++;
            end
            if (rsp_event_kind !== exp_ev.kind) begin
               $error("event_kind: expected %0d, actual %0d", exp_ev.kind, rsp_event_kind);
               error_count++;
            end
            if (rsp_last !== exp_ev.last) begin
               $error("last: expected %0d, actual %0d", exp_ev.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   function automatic logic [TIMER_BITS-1:0] load_count(
      input logic [bpc_pkg::REG_WIDTH-1:0] period);
      longint unsigned ticks;
      ticks = period;
      if (ticks == 0) ticks = 1;
      if (ticks > (64'd1 << TIMER_BITS) - 1) ticks = (64'd1 << TIMER_BITS) - 1;
      return ticks[TIMER_BITS-1:0];
   endfunction

   task automatic reset_classifier_state();
      long_ticks_cfg = bpc_pkg::LONG_PRESS_RESET;
      repeat_ticks_cfg = bpc_pkg::REPEAT_PERIOD_RESET;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         press_state[b] = bpc_pkg::PH_IDLE;
         count_left[b] = '0;
         held_down[b] = 1'b0;
      end
   endtask

   task automatic predict_events(input logic op, input logic [1:0] btn, input logic lvl);
      logic [1:0] ids [NUM_BUTTONS];
      bpc_pkg::event_kind_type kinds [NUM_BUTTONS];
      int n;
      press_event_type ev;
      n = 0;
      if (op == bpc_pkg::OP_LEVEL) begin
         if (btn < NUM_BUTTONS) begin
            if (lvl == bpc_pkg::LEVEL_PRESSED) begin
               held_down[btn] = 1'b1;
               if (press_state[btn] == bpc_pkg::PH_IDLE) begin
                  press_state[btn] = bpc_pkg::PH_PRESSED;
                  count_left[btn] = load_count(long_ticks_cfg);
               end
            end else if (held_down[btn]) begin
               held_down[btn] = 1'b0;
               if (press_state[btn] == bpc_pkg::PH_PRESSED) begin
                  ids[n] = btn;
                  kinds[n] = bpc_pkg::EV_SHORT;
                  n++;
               end
               press_state[btn] = bpc_pkg::PH_IDLE;
               count_left[btn] = '0;
            end
         end
      end else begin
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (press_state[b] != bpc_pkg::PH_IDLE) begin
               if (count_left[b] > TIMER_BITS'(1)) begin
                  count_left[b] = count_left[b] - TIMER_BITS'(1);
               end else begin
                  ids[n] = b[1:0];
                  kinds[n] = (press_state[b] == bpc_pkg::PH_PRESSED) ?
                             bpc_pkg::EV_LONG : bpc_pkg::EV_REPEAT;
                  press_state[b] = (press_state[b] == bpc_pkg::PH_PRESSED) ?
                                   bpc_pkg::PH_LONG : bpc_pkg::PH_REPEAT;
                  count_left[b] = load_count(repeat_ticks_cfg);
                  n++;
               end
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         ev.button_id = ids[i];
         ev.kind = kinds[i];
         ev.last = (i == n - 1);
         pending_events.push_back(ev);
      end
   endtask

   task automatic send_request(input logic op, input logic [1:0] btn, input logic lvl);
      if (!quiet_run && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_button <= btn;
      req_level <= lvl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_events(op, btn, lvl);
   endtask

   task automatic send_ticks(input int count);
      for (int i = 0; i < count; i++) begin
         send_request(bpc_pkg::OP_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_registers(input logic [bpc_pkg::REG_WIDTH-1:0] long_val,
                                  input logic [bpc_pkg::REG_WIDTH-1:0] repeat_val);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index <= bpc_pkg::CSR_LONG_PRESS;
      csr_wdata <= long_val;
      @(posedge clock);
      long_ticks_cfg = long_val;
      csr_index <= bpc_pkg::CSR_REPEAT_PERIOD;
      csr_wdata <= repeat_val;
      @(posedge clock);
      repeat_ticks_cfg = repeat_val;
      csr_write_en <= 1'b0;
   endtask

   task automatic test_reset_registers();
      send_request(bpc_pkg::OP_LEVEL, 2'd1, bpc_pkg::LEVEL_PRESSED);
      send_ticks(30);
      send_request(bpc_pkg::OP_LEVEL, 2'd1, LEVEL_RELEASED);
   endtask

   task automatic test_short_presses();
      write_registers(16'd3, 16'd2);
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         send_request(bpc_pkg::OP_LEVEL, 2'(b), bpc_pkg::LEVEL_PRESSED);
         send_ticks(1);
         send_request(bpc_pkg::OP_LEVEL, 2'(b), LEVEL_RELEASED);
      end
      send_request(bpc_pkg::OP_LEVEL, 2'd2, bpc_pkg::LEVEL_PRESSED);
      send_request(bpc_pkg::OP_LEVEL, 2'd2, LEVEL_RELEASED);
   endtask

   task automatic test_ignored_requests();
      send_request(bpc_pkg::OP_LEVEL, 2'd2, LEVEL_RELEASED);
      send_request(bpc_pkg::OP_LEVEL, 2'd3, bpc_pkg::LEVEL_PRESSED);
      send_request(bpc_pkg::OP_LEVEL, 2'd3, LEVEL_RELEASED);
      send_request(bpc_pkg::OP_TICK, 2'd3, bpc_pkg::LEVEL_PRESSED);
   endtask

   task automatic test_press_while_held();
      send_request(bpc_pkg::OP_LEVEL, 2'd0, bpc_pkg::LEVEL_PRESSED);
      send_request(bpc_pkg::OP_LEVEL, 2'd0, bpc_pkg::LEVEL_PRESSED);
      send_ticks(3);
      send_request(bpc_pkg::OP_LEVEL, 2'd0, bpc_pkg::LEVEL_PRESSED);
      send_ticks(4);
      send_request(bpc_pkg::OP_LEVEL, 2'd0, LEVEL_RELEASED);
      send_request(bpc_pkg::OP_LEVEL, 2'd0, LEVEL_RELEASED);
   endtask

   task automatic test_simultaneous_expiry();
      write_registers(16'd1, 16'd1);
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         send_request(bpc_pkg::OP_LEVEL, 2'(b), bpc_pkg::LEVEL_PRESSED);
      end
      send_ticks(2);
      send_request(bpc_pkg::OP_LEVEL, 2'd1, LEVEL_RELEASED);
      send_ticks(1);
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         send_request(bpc_pkg::OP_LEVEL, 2'(b), LEVEL_RELEASED);
      end
   endtask

   task automatic test_zero_period();
      write_registers(16'd0, 16'd0);
      send_request(bpc_pkg::OP_LEVEL, 2'd0, bpc_pkg::LEVEL_PRESSED);
      send_request(bpc_pkg::OP_LEVEL, 2'd0, LEVEL_RELEASED);
      send_request(bpc_pkg::OP_LEVEL, 2'd2, bpc_pkg::LEVEL_PRESSED);
      send_ticks(3);
      send_request(bpc_pkg::OP_LEVEL, 2'd2, LEVEL_RELEASED);
   endtask

   task automatic test_extreme_period();
      write_registers(16'hFFFF, 16'hFFFF);
      send_request(bpc_pkg::OP_LEVEL, 2'd0, bpc_pkg::LEVEL_PRESSED);
      send_ticks(30);
      send_request(bpc_pkg::OP_LEVEL, 2'd0, LEVEL_RELEASED);
   endtask

   task automatic test_random_traffic();
      logic [bpc_pkg::REG_WIDTH-1:0] periods [2];
      int pick;
      for (int phase = 0; phase < 5; phase++) begin
         for (int r = 0; r < 2; r++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) periods[r] = '0;
            else if (pick == 1) periods[r] = bpc_pkg::REG_WIDTH'($urandom_range(9, 40));
            else periods[r] = bpc_pkg::REG_WIDTH'($urandom_range(1, 6));
         end
         write_registers(periods[0], periods[1]);
         quiet_run = (phase == 4);
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               send_request(bpc_pkg::OP_TICK, 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)));
            end else if (pick < 92) begin
               send_request(bpc_pkg::OP_LEVEL, 2'($urandom_range(0, NUM_BUTTONS - 1)),
                            1'($urandom_range(0, 1)));
            end else begin
               send_request(bpc_pkg::OP_LEVEL, 2'd3, 1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   initial begin
      reset_classifier_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_registers();
      test_short_presses();
      test_ignored_requests();
      test_press_while_held();
      test_simultaneous_expiry();
      test_zero_period();
      test_extreme_period();
      test_random_traffic();
      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
